FILE: hw/rtl/dsi_pkg.sv
// ----------------------------------------------------------------------------
// dsi_pkg
// Shared types and constants for the decimal text to scaled integer converter.
// ----------------------------------------------------------------------------
package dsi_pkg;

    localparam int unsigned C_ACC_W       = 128;
    localparam int unsigned C_HALF_W      = 64;
    localparam int unsigned C_CNT_W       = 6;
    localparam int unsigned C_MAX_PRECISION = 38;

    localparam logic [7:0] C_CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] C_CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] C_CHAR_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] C_CHAR_MINUS = 8'h2D;  // '-'

    localparam logic [C_CNT_W-1:0] C_COUNT_MAX = {C_CNT_W{1'b1}};

    // configuration register indexes
    localparam logic C_REG_PRECISION = 1'b0;
    localparam logic C_REG_SCALE     = 1'b1;

    localparam logic [C_CNT_W-1:0] C_PRECISION_RESET = 6'd18;
    localparam logic [C_CNT_W-1:0] C_SCALE_RESET     = 6'd0;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_DIGITS  = 2'd1,
        ST_BAD_SYMBOL = 2'd2,
        ST_TOO_MANY   = 2'd3
    } t_status;

    typedef enum logic {
        ALU_MAC = 1'b0,   // a*10 + digit
        ALU_NEG = 1'b1    // two's complement negate
    } t_alu_op;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_PAD  = 5'b00100,
        S_NEG  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

FILE: hw/rtl/dsi_alu.sv
// ----------------------------------------------------------------------------
// dsi_alu
// Shared 128-bit arithmetic unit: multiply by ten and add a digit, or negate.
// ----------------------------------------------------------------------------
module dsi_alu (
    input  dsi_pkg::t_alu_op             i_op,
    input  logic [dsi_pkg::C_ACC_W-1:0]  i_a,
    input  logic [3:0]                   i_digit,
    output logic [dsi_pkg::C_ACC_W-1:0]  o_sum
);
    import dsi_pkg::*;

    always_comb begin
        case (i_op)
            // 10*a = 8*a + 2*a, digit rides in as a third addend
            ALU_MAC: o_sum = (i_a << 3) + (i_a << 1) + {{(C_ACC_W-4){1'b0}}, i_digit};
            ALU_NEG: o_sum = ~i_a + {{(C_ACC_W-1){1'b0}}, 1'b1};
            default: o_sum = i_a;
        endcase
    end

endmodule

FILE: hw/rtl/decimal_string_to_scaled_integer.sv
// ----------------------------------------------------------------------------
// decimal_string_to_scaled_integer
// Bytes of a text are taken at one per cycle until the last byte. Then the
//   text is checked, zero-padded, negated if it had a minus and registered as
//   the result (a failed text skips pad and negate). Pad digits (scale minus
//   fraction digits, only when a dot was seen) each take one pass through the
//   shared 128-bit multiply-by-ten unit.
// Input is stalled from the last byte until the result is registered.
// Reset (synchronous, active low) clears the text state and loads
//   precision 18, scale 0.
// ----------------------------------------------------------------------------
module decimal_string_to_scaled_integer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [dsi_pkg::C_CNT_W-1:0]         i_cfg_data,
    // character requests
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_last,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dsi_pkg::C_HALF_W-1:0]        o_value_low,
    output logic signed [dsi_pkg::C_HALF_W-1:0] o_value_high,
    output logic [1:0]                          o_status
);
    import dsi_pkg::*;

    t_state               r_state, n_state;
    logic [C_CNT_W-1:0]   r_precision, r_scale;
    logic                 r_first, n_first;
    logic                 r_neg, n_neg;
    logic                 r_dot, n_dot;
    logic                 r_lead, n_lead;
    logic                 r_any, n_any;
    logic                 r_sym, n_sym;
    logic [C_CNT_W-1:0]   r_icnt, n_icnt;
    logic [C_CNT_W-1:0]   r_fcnt, n_fcnt;
    logic [C_ACC_W-1:0]   r_acc, n_acc;
    t_status              r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    logic [C_HALF_W-1:0]  r_out_low, n_out_low;
    logic [C_HALF_W-1:0]  r_out_high, n_out_high;
    logic [1:0]           r_out_status, n_out_status;

    t_alu_op              alu_op;
    logic [3:0]           alu_digit;
    logic [C_ACC_W-1:0]   alu_sum;
    logic                 in_acc;
    logic                 is_digit;
    logic [7:0]           digit_full;
    logic [C_CNT_W:0]     digits;
    logic [C_CNT_W-1:0]   limit;
    t_status              chk_status;
    logic                 out_free;

    dsi_alu u_alu (
        .i_op    (alu_op),
        .i_a     (r_acc),
        .i_digit (alu_digit),
        .o_sum   (alu_sum)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && (r_state == S_IDLE);
    assign digit_full   = i_char_code - C_CHAR_ZERO;
    assign is_digit     = (i_char_code >= C_CHAR_ZERO) && (i_char_code <= C_CHAR_NINE);
    assign alu_op       = (r_state == S_NEG) ? ALU_NEG : ALU_MAC;
    assign alu_digit    = (r_state == S_IDLE) ? digit_full[3:0] : 4'd0;
    assign out_free     = !r_out_valid || !i_out_stall;

    // precision above the supported maximum is clamped
    assign limit  = (r_precision > C_CNT_W'(C_MAX_PRECISION)) ?
                    C_CNT_W'(C_MAX_PRECISION) : r_precision;
    assign digits = {1'b0, r_icnt} + (r_dot ? {1'b0, r_scale} : {(C_CNT_W+1){1'b0}});

    always_comb begin
        if (r_sym)
            chk_status = ST_BAD_SYMBOL;
        else if (!r_any)
            chk_status = ST_NO_DIGITS;
        else if (digits > {1'b0, limit})
            chk_status = ST_TOO_MANY;
        else
            chk_status = ST_OK;
    end

    always_comb begin
        n_state      = r_state;
        n_first      = r_first;
        n_neg        = r_neg;
        n_dot        = r_dot;
        n_lead       = r_lead;
        n_any        = r_any;
        n_sym        = r_sym;
        n_icnt       = r_icnt;
        n_fcnt       = r_fcnt;
        n_acc        = r_acc;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_low    = r_out_low;
        n_out_high   = r_out_high;
        n_out_status = r_out_status;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_first = 1'b0;
                    if (r_first && i_char_code == C_CHAR_MINUS) begin
                        n_neg = 1'b1;
                    end else if (i_char_code == C_CHAR_DOT && !r_dot) begin
                        n_dot = 1'b1;
                    end else if (!is_digit) begin
                        n_sym = 1'b1;
                    end else begin
                        n_any = 1'b1;
                        if (i_char_code != C_CHAR_ZERO)
                            n_lead = 1'b0;
                        if (!r_dot) begin
                            if (!n_lead && r_icnt != C_COUNT_MAX)
                                n_icnt = r_icnt + 1'b1;
                            n_acc = alu_sum;
                        end else begin
                            if (r_fcnt < r_scale)
                                n_acc = alu_sum;
                            if (r_fcnt != C_COUNT_MAX)
                                n_fcnt = r_fcnt + 1'b1;
                        end
                    end
                    if (i_last)
                        n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_status = chk_status;
                if (chk_status == ST_OK) begin
                    n_state = S_PAD;
                end else begin
                    n_acc   = '0;
                    n_state = S_DONE;
                end
            end
            S_PAD: begin
                // fraction count doubles as the pad counter
                if (r_dot && r_fcnt < r_scale) begin
                    n_acc  = alu_sum;
                    n_fcnt = r_fcnt + 1'b1;
                end else begin
                    n_state = S_NEG;
                end
            end
            S_NEG: begin
                if (r_neg)
                    n_acc = alu_sum;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_low    = r_acc[C_HALF_W-1:0];
                    n_out_high   = r_acc[C_ACC_W-1:C_HALF_W];
                    n_out_status = r_status;
                    n_first      = 1'b1;
                    n_neg        = 1'b0;
                    n_dot        = 1'b0;
                    n_lead       = 1'b1;
                    n_any        = 1'b0;
                    n_sym        = 1'b0;
                    n_icnt       = '0;
                    n_fcnt       = '0;
                    n_acc        = '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_precision <= C_PRECISION_RESET;
            r_scale     <= C_SCALE_RESET;
            r_first     <= 1'b1;
            r_neg       <= 1'b0;
            r_dot       <= 1'b0;
            r_lead      <= 1'b1;
            r_any       <= 1'b0;
            r_sym       <= 1'b0;
            r_icnt      <= '0;
            r_fcnt      <= '0;
            r_acc       <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_neg       <= n_neg;
            r_dot       <= n_dot;
            r_lead      <= n_lead;
            r_any       <= n_any;
            r_sym       <= n_sym;
            r_icnt      <= n_icnt;
            r_fcnt      <= n_fcnt;
            r_acc       <= n_acc;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == C_REG_PRECISION)
                    r_precision <= i_cfg_data;
                else
                    r_scale <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_low    <= n_out_low;
        r_out_high   <= n_out_high;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_value_low  = r_out_low;
    assign o_value_high = r_out_high;
    assign o_status     = r_out_status;

endmodule

FILE: hw/rtl/dsi_checker.sv
// ----------------------------------------------------------------------------
// dsi_checker
// Port-level checks for the decimal text to scaled integer converter.
// ----------------------------------------------------------------------------
module dsi_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_last,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [dsi_pkg::C_HALF_W-1:0]        o_value_low,
    input logic signed [dsi_pkg::C_HALF_W-1:0] o_value_high,
    input logic [1:0]                          o_status
);
    import dsi_pkg::*;

    // a failed text always carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_value_low == '0 && o_value_high == '0))
        else $error("failed text with nonzero value");

    // last byte closes the text: input stalls until the result is built
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last) |=> o_in_stall)
        else $error("input not stalled after last byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        ($stable(o_value_low) && $stable(o_value_high) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind decimal_string_to_scaled_integer dsi_checker u_dsi_checker (.*);

FILE: sim/dsi_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsi_result_checker
// Watches the configuration port and both request channels of the decimal
// text converter, predicts each result from the accepted characters and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module dsi_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [dsi_pkg::C_CNT_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_last,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [63:0]                  i_value_low,
    input  logic signed [63:0]           i_value_high,
    input  logic [1:0]                   i_status,
    output int                           o_fail_count,
    output int                           o_pending
);
    import dsi_pkg::*;

    localparam int C_MAX_REPORTS = 10;

    typedef struct {
        logic [63:0]        value_low;
        logic signed [63:0] value_high;
        t_status            status;
    } t_conv_result;

    t_conv_result scaled_q[$];

    // register copies
    logic [C_CNT_W-1:0] precision_r;
    logic [C_CNT_W-1:0] scale_r;

    // text state
    logic               at_first;
    logic               negative;
    logic               dot_seen;
    logic               leading_zeros;
    logic               digit_seen;
    logic               bad_symbol;
    logic [C_CNT_W-1:0] int_digits;
    logic [C_CNT_W-1:0] frac_digits;
    logic [127:0]       acc;

    int                 result_index;

    task automatic clear_text();
        at_first      = 1'b1;
        negative      = 1'b0;
        dot_seen      = 1'b0;
        leading_zeros = 1'b1;
        digit_seen    = 1'b0;
        bad_symbol    = 1'b0;
        int_digits    = '0;
        frac_digits   = '0;
        acc           = '0;
    endtask

    task automatic convert_char(input logic [7:0] ch, input logic is_last);
        t_conv_result       res;
        logic [127:0]       digit;
        int                 limit;
        int                 digits;
        int                 k;
        digit = 128'(ch - C_CHAR_ZERO);
        if (at_first && ch == C_CHAR_MINUS) begin
            negative = 1'b1;
        end else if (ch == C_CHAR_DOT && !dot_seen) begin
            dot_seen = 1'b1;
        end else if (ch < C_CHAR_ZERO || ch > C_CHAR_NINE) begin
            bad_symbol = 1'b1;
        end else begin
            digit_seen = 1'b1;
            if (ch != C_CHAR_ZERO) begin
                leading_zeros = 1'b0;
            end
            if (!dot_seen) begin
                if (!leading_zeros && int_digits != C_COUNT_MAX) begin
                    int_digits = int_digits + 1'b1;
                end
                acc = acc * 128'd10 + digit;
            end else begin
                // fraction digits past the scale are dropped
                if (frac_digits < scale_r) begin
                    acc = acc * 128'd10 + digit;
                end
                if (frac_digits != C_COUNT_MAX) begin
                    frac_digits = frac_digits + 1'b1;
                end
            end
        end
        at_first = 1'b0;

        if (is_last) begin
            limit  = (precision_r > C_MAX_PRECISION) ? C_MAX_PRECISION : int'(precision_r);
            digits = int'(int_digits) + (dot_seen ? int'(scale_r) : 0);
            if (bad_symbol) begin
                res.status = ST_BAD_SYMBOL;
            end else if (!digit_seen) begin
                res.status = ST_NO_DIGITS;
            end else if (digits > limit) begin
                res.status = ST_TOO_MANY;
            end else begin
                res.status = ST_OK;
            end
            if (res.status == ST_OK) begin
                // zero pad only when the text had a dot
                if (dot_seen) begin
                    for (k = int'(frac_digits); k < int'(scale_r); k++) begin
                        acc = acc * 128'd10;
                    end
                end
                if (negative) begin
                    acc = ~acc + 128'd1;
                end
                res.value_low  = acc[63:0];
                res.value_high = acc[127:64];
            end else begin
                res.value_low  = '0;
                res.value_high = '0;
            end
            scaled_q = {scaled_q, res};
            clear_text();
        end
    endtask

    task automatic report_failure(input string what);
        if (o_fail_count < C_MAX_REPORTS) begin
            $display("[%0t] result %0d: %s", $realtime, result_index, what);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic check_result();
        t_conv_result want;
        if (scaled_q.size() == 0) begin
            report_failure($sformatf("unexpected result low %h high %h status %0d",
                                     i_value_low, i_value_high, i_status));
        end else begin
            want = scaled_q.pop_front();
            if (i_value_low !== want.value_low || i_value_high !== want.value_high ||
                i_status !== want.status) begin
                report_failure($sformatf(
                    "expected low %h high %h status %0d, got low %h high %h status %0d",
                    want.value_low, want.value_high, want.status,
                    i_value_low, i_value_high, i_status));
            end
        end
        result_index = result_index + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            precision_r = C_PRECISION_RESET;
            scale_r     = C_SCALE_RESET;
            clear_text();
            scaled_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == C_REG_PRECISION) begin
                    precision_r = i_cfg_data;
                end else begin
                    scale_r = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                convert_char(i_char_code, i_last);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_pending = scaled_q.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives decimal texts into the converter: directed corner cases first, then
// random well-formed numbers mixed with noise over a series of precision and
// scale settings and three idle/stall patterns. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import dsi_pkg::*;

    localparam int C_PHASES         = 12;
    localparam int C_ITEMS_PER_PHASE = 140;
    localparam int C_SETTLE         = 8;
    localparam int C_DRAIN_CYCLES   = 80;
    localparam int C_CYCLE_LIMIT    = 500000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_index;
    logic [C_CNT_W-1:0]         i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [7:0]                 i_char_code;
    logic                       i_last;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [C_HALF_W-1:0]        o_value_low;
    logic signed [C_HALF_W-1:0] o_value_high;
    logic [1:0]                 o_status;

    int                         fail_count;
    int                         pending;
    int                         cycle_count;
    int                         send_idle_pct;
    int                         recv_idle_pct;
    logic [7:0]                 text_bytes[$];

    // precision / scale per random phase; some entries lie above the supported
    // maximum precision of 38 on purpose
    int prec_tbl[C_PHASES]  = '{18, 38, 1, 38, 20, 1, 12, 38, 63, 5, 30, 0};
    int scale_tbl[C_PHASES] = '{0, 38, 0, 0, 6, 1, 4, 19, 63, 2, 12, 0};

    decimal_string_to_scaled_integer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value_low  (o_value_low),
        .o_value_high (o_value_high),
        .o_status     (o_status)
    );

    dsi_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_value_low  (o_value_low),
        .i_value_high (o_value_high),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= C_CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // one character request; valid stays up between back-to-back requests
    task automatic send_char(input logic [7:0] ch, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= ch;
        i_last      <= is_last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_bytes.size(); i++) begin
            send_char(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    task automatic send_string(input string s);
        int i;
        text_bytes.delete();
        for (i = 0; i < s.len(); i++) begin
            text_bytes = {text_bytes, s[i]};
        end
        send_text();
    endtask

    task automatic send_byte(input logic [7:0] ch);
        text_bytes.delete();
        text_bytes = {text_bytes, ch};
        send_text();
    endtask

    // both registers on consecutive cycles, write enable held high
    task automatic set_config(input int prec, input int scl);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= C_REG_PRECISION;
        i_cfg_data  <= C_CNT_W'(prec);
        @(posedge i_clk);
        i_cfg_index <= C_REG_SCALE;
        i_cfg_data  <= C_CNT_W'(scl);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // sample at the falling edge so the checker has settled for this cycle
    task automatic wait_drained(input int extra);
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic make_number_text(input int prec, input int scl);
        int  lim;
        int  room;
        int  n_lead;
        int  n_int;
        int  n_frac;
        int  i;
        bit  with_dot;
        text_bytes.delete();
        lim      = (prec > C_MAX_PRECISION) ? C_MAX_PRECISION : prec;
        with_dot = ($urandom_range(2) != 0);
        if ($urandom_range(1)) begin
            text_bytes = {text_bytes, C_CHAR_MINUS};
        end
        n_lead = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        for (i = 0; i < n_lead; i++) begin
            text_bytes = {text_bytes, C_CHAR_ZERO};
        end
        room = with_dot ? lim - scl : lim;
        if (room < 0) begin
            room = 0;
        end
        // now and then one digit too many
        n_int = $urandom_range(room + (($urandom_range(7) == 0) ? 1 : 0));
        for (i = 0; i < n_int; i++) begin
            text_bytes = {text_bytes, 8'(C_CHAR_ZERO +
                          ((i == 0) ? $urandom_range(9, 1) : $urandom_range(9)))};
        end
        if (with_dot) begin
            text_bytes = {text_bytes, C_CHAR_DOT};
            n_frac = $urandom_range(scl + 2);
            for (i = 0; i < n_frac; i++) begin
                text_bytes = {text_bytes, 8'(C_CHAR_ZERO + $urandom_range(9))};
            end
        end
        if (text_bytes.size() == 0) begin
            text_bytes = {text_bytes, 8'(C_CHAR_ZERO + $urandom_range(9))};
        end
    endtask

    task automatic make_noise_text();
        int len;
        int i;
        len = $urandom_range(12, 1);
        text_bytes.delete();
        for (i = 0; i < len; i++) begin
            case ($urandom_range(3))
                0: begin
                    text_bytes = {text_bytes, 8'($urandom_range(255))};
                end
                1: begin
                    text_bytes = {text_bytes, 8'(C_CHAR_ZERO + $urandom_range(9))};
                end
                2: begin
                    text_bytes = {text_bytes, C_CHAR_DOT};
                end
                default: begin
                    text_bytes = {text_bytes, C_CHAR_MINUS};
                end
            endcase
        end
    endtask

    initial begin
        int p;
        int sent;
        send_idle_pct = 19;
        recv_idle_pct = 78;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = C_REG_PRECISION;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_char_code   = '0;
        i_last        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: precision 18, scale 0
        send_string("0");
        send_string("-0");
        send_string("123");
        send_string("-9");
        send_string("1.5");
        send_string("-");
        send_string(".");
        send_string("-.");
        send_string("1-2");
        send_string("--1");
        send_string("1.2.3");
        send_string("12a");
        send_string("/");
        send_string(":");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_string("999999999999999999");
        send_string("1999999999999999999");
        send_string("0000000000000000000001");
        wait_drained(C_SETTLE);

        set_config(38, 5);
        send_string("1.2345678");
        send_string("-1.2");
        send_string("-0.00001");
        send_string("5");
        send_string(".5");
        send_string("123456789012345678901234567890123.5");
        send_string("1234567890123456789012345678901234.5");
        send_string("12345678901234567890123456789012345");
        wait_drained(C_SETTLE);

        set_config(38, 0);
        send_string("99999999999999999999999999999999999999");
        send_string("-99999999999999999999999999999999999999");
        send_string("199999999999999999999999999999999999999");
        wait_drained(C_SETTLE);

        for (p = 0; p < C_PHASES; p++) begin
            case (p / 4)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            set_config(prec_tbl[p], scale_tbl[p]);
            sent = 0;
            while (sent < C_ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 85) begin
                    make_number_text(prec_tbl[p], scale_tbl[p]);
                end else begin
                    make_noise_text();
                end
                sent = sent + text_bytes.size();
                send_text();
            end
            wait_drained(C_SETTLE);
        end

        wait_drained(C_DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
